// ===== hdl/sacf_pkg.sv =====
// ============================================================================
// sacf_pkg
// Shared types, constants and helpers of the set-associative FIFO cache core.
// ============================================================================
package sacf_pkg;

    // default sizing, handed to the top level parameters
    localparam int DEF_MAX_SETS   = 256;
    localparam int DEF_MAX_WAYS   = 8;
    localparam int DEF_ADDR_WIDTH = 48;

    // fixed field widths
    localparam int IN_ADDR_W = 48;
    localparam int CNT_W     = 32;
    localparam int RANK_W    = 4;
    localparam int OFF_W     = 5;
    localparam int SETB_W    = 4;
    localparam int WAYS_W    = 4;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [RANK_W-1:0] RANK_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SET_BITS    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WAYS        = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_INDEX_MODE  = 2'd3;

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic [OFF_W-1:0]  offset_bits;
        logic [SETB_W-1:0] set_bits;
        logic [WAYS_W-1:0] ways;
        logic              index_mode;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        offset_bits: 5'd6,
        set_bits:    4'd0,
        ways:        4'd1,
        index_mode:  1'b0
    };

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction

    function automatic logic [RANK_W-1:0] rank_bump(input logic [RANK_W-1:0] r);
        return (r == RANK_MAX) ? r : r + RANK_W'(1);
    endfunction

endpackage

// ===== hdl/sacf_regs.sv =====
// ============================================================================
// sacf_regs
// Configuration register file behind an APB-style slave port.
// ============================================================================
module sacf_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sacf_pkg::PADDR_W-1:0]  paddr,
    input  logic [sacf_pkg::PDATA_W-1:0]  pwdata,
    output logic [sacf_pkg::PDATA_W-1:0]  prdata,
    output sacf_pkg::t_cfg                o_cfg
);

    sacf_pkg::t_cfg                      r_cfg;
    logic                                w_wr;
    logic [sacf_pkg::REG_IDX_W-1:0]      w_idx;

    assign w_wr  = psel & penable & pwrite;
    assign w_idx = paddr[sacf_pkg::PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= sacf_pkg::CFG_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                sacf_pkg::REG_OFFSET_BITS: begin
                    r_cfg.offset_bits <= pwdata[sacf_pkg::OFF_W-1:0];
                end
                sacf_pkg::REG_SET_BITS: begin
                    r_cfg.set_bits <= pwdata[sacf_pkg::SETB_W-1:0];
                end
                sacf_pkg::REG_WAYS: begin
                    r_cfg.ways <= pwdata[sacf_pkg::WAYS_W-1:0];
                end
                sacf_pkg::REG_INDEX_MODE: begin
                    r_cfg.index_mode <= pwdata[0];
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            sacf_pkg::REG_OFFSET_BITS: prdata = sacf_pkg::PDATA_W'(r_cfg.offset_bits);
            sacf_pkg::REG_SET_BITS:    prdata = sacf_pkg::PDATA_W'(r_cfg.set_bits);
            sacf_pkg::REG_WAYS:        prdata = sacf_pkg::PDATA_W'(r_cfg.ways);
            sacf_pkg::REG_INDEX_MODE:  prdata = sacf_pkg::PDATA_W'(r_cfg.index_mode);
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/sacf_addr_split.sv =====
// ============================================================================
// sacf_addr_split
// Clamps the configuration and splits an address into set index and tag.
// ============================================================================
module sacf_addr_split #(
    parameter int MAX_SETS   = sacf_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS   = sacf_pkg::DEF_MAX_WAYS,
    parameter int ADDR_WIDTH = sacf_pkg::DEF_ADDR_WIDTH
) (
    input  logic [ADDR_WIDTH-1:0]                                 i_addr,
    input  sacf_pkg::t_cfg                                        i_cfg,
    output logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0]    o_set,
    output logic [ADDR_WIDTH-1:0]                                 o_tag,
    output logic [sacf_pkg::WAYS_W-1:0]                           o_nw
);

    localparam int SETB   = $clog2(MAX_SETS);
    localparam int SIDX_W = (SETB > 0) ? SETB : 1;
    localparam int CW     = $clog2(ADDR_WIDTH + 1);

    logic [CW-1:0]         w_sb;
    logic [CW-1:0]         w_off_raw;
    logic [CW-1:0]         w_lim;
    logic [CW-1:0]         w_off;
    logic [CW-1:0]         w_tw;
    logic [ADDR_WIDTH-1:0] w_set_src;
    logic [ADDR_WIDTH-1:0] w_tag_src;
    logic [ADDR_WIDTH-1:0] w_tmask;
    logic [SIDX_W-1:0]     w_smask;

    always_comb begin
        w_sb      = (int'(i_cfg.set_bits) > SETB) ? CW'(SETB) : CW'(i_cfg.set_bits);
        w_off_raw = CW'(i_cfg.offset_bits);
        w_lim     = CW'(ADDR_WIDTH) - w_sb;
        w_off     = (w_off_raw > w_lim) ? w_lim : w_off_raw;
        w_tw      = w_lim - w_off;

        if (i_cfg.index_mode) begin
            // set from the top bits, tag just above the offset
            w_set_src = (w_sb == '0) ? '0 : (i_addr >> w_lim);
            w_tag_src = i_addr >> w_off;
        end else begin
            w_set_src = i_addr >> w_off;
            w_tag_src = i_addr >> (w_off + w_sb);
        end

        w_smask = ~({SIDX_W{1'b1}} << w_sb);
        w_tmask = ~({ADDR_WIDTH{1'b1}} << w_tw);
        o_set   = w_set_src[SIDX_W-1:0] & w_smask;
        o_tag   = w_tag_src & w_tmask;

        if (i_cfg.ways == '0) begin
            o_nw = sacf_pkg::WAYS_W'(1);
        end else if (int'(i_cfg.ways) > MAX_WAYS) begin
            o_nw = sacf_pkg::WAYS_W'(MAX_WAYS);
        end else begin
            o_nw = i_cfg.ways;
        end
    end

endmodule

// ===== hdl/sacf_tag_store.sv =====
// ============================================================================
// sacf_tag_store
// Tag memory with a registered read port and the shared tag comparator.
// ============================================================================
module sacf_tag_store #(
    parameter int DEPTH_W = 11,
    parameter int DATA_W  = sacf_pkg::DEF_ADDR_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  logic [DEPTH_W-1:0] i_rd_addr,
    input  logic               i_wr_en,
    input  logic [DEPTH_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]  i_wr_data,
    input  logic [DATA_W-1:0]  i_cmp_tag,
    output logic               o_match
);

    logic [DATA_W-1:0] r_mem [2**DEPTH_W];
    logic [DATA_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_match = (r_q == i_cmp_tag);

endmodule

// ===== hdl/set_assoc_cache_fifo_sim_core.sv =====
// ============================================================================
// set_assoc_cache_fifo_sim_core
// Set-associative cache tag model with FIFO replacement and running counters.
// ============================================================================
// One access (op, address) is taken per input beat when o_in_ready is high;
// the core then works on it alone and drops o_in_ready until it is done.
// Each access yields one output beat: hit, mem_read, mem_write and the four
// saturating counters as they stand after the access.
// Steps: a decode step, one tag compare per way scanned through the single
// shared comparator, an allocation step on a miss, a finish step. A hit
// ends the scan at its way, a miss scans every configured way. The core is
// ready again from the edge that loads the output register.
// The output register holds the result while the receiver stalls; the next
// access is still accepted and processed, and only waits in its finish step
// until the held beat is taken.
// Reset clears the counters and sets the configuration to its defaults, then
// a clearing pass zeroes the valid and rank rows of every set; no access is
// accepted during it, configuration writes are taken as ever.
// ============================================================================
module set_assoc_cache_fifo_sim_core #(
    parameter int MAX_SETS   = sacf_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS   = sacf_pkg::DEF_MAX_WAYS,
    parameter int ADDR_WIDTH = sacf_pkg::DEF_ADDR_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sacf_pkg::PADDR_W-1:0]      paddr,
    input  logic [sacf_pkg::PDATA_W-1:0]      pwdata,
    output logic [sacf_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    // access input
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_op,
    input  logic [sacf_pkg::IN_ADDR_W-1:0]    i_address,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_hit,
    output logic                              o_mem_read,
    output logic                              o_mem_write,
    output logic [sacf_pkg::CNT_W-1:0]        o_hit_count,
    output logic [sacf_pkg::CNT_W-1:0]        o_miss_count,
    output logic [sacf_pkg::CNT_W-1:0]        o_read_count,
    output logic [sacf_pkg::CNT_W-1:0]        o_write_count
);

    localparam int SETB   = $clog2(MAX_SETS);
    localparam int SIDX_W = (SETB > 0) ? SETB : 1;
    localparam int WIDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCMP_W = ((WIDX_W > sacf_pkg::WAYS_W) ? WIDX_W : sacf_pkg::WAYS_W) + 1;
    localparam int MW     = sacf_pkg::RANK_W + 1;
    localparam int MROW_W = MAX_WAYS * MW;
    localparam int EXT_W  = ADDR_WIDTH + sacf_pkg::IN_ADDR_W;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    sacf_pkg::t_cfg                  w_cfg;
    logic [2:0]                      r_state;
    logic [2:0]                      n_state;
    logic [SIDX_W-1:0]               r_clr;
    logic                            r_op;
    logic [ADDR_WIDTH-1:0]           r_addr;
    logic [EXT_W-1:0]                w_addr_ext;
    logic [SIDX_W-1:0]               w_set;
    logic [ADDR_WIDTH-1:0]           w_tag;
    logic [sacf_pkg::WAYS_W-1:0]     w_nw;
    logic [SIDX_W-1:0]               r_set;
    logic [ADDR_WIDTH-1:0]           r_tag;
    logic [sacf_pkg::WAYS_W-1:0]     r_nw;
    logic [WIDX_W-1:0]               r_way;
    logic                            r_hit;
    logic                            w_match;
    logic                            w_hit;
    logic                            w_last;
    logic                            w_load;

    logic [MROW_W-1:0]               r_meta_mem [2**SIDX_W];
    logic [MROW_W-1:0]               r_meta_q;
    logic                            w_meta_we;
    logic [SIDX_W-1:0]               w_meta_waddr;
    logic [MROW_W-1:0]               w_meta_wdata;
    logic [MROW_W-1:0]               w_meta_new;
    logic                            w_vld  [MAX_WAYS];
    logic [sacf_pkg::RANK_W-1:0]     w_rank [MAX_WAYS];

    logic                            w_found;
    logic                            w_repl;
    logic [WIDX_W-1:0]               w_vic;

    logic                            w_tag_re;
    logic [SIDX_W+WIDX_W-1:0]        w_tag_raddr;
    logic                            w_tag_we;

    logic                            r_out_valid;
    logic                            r_out_hit;
    logic                            r_out_op;
    logic [sacf_pkg::CNT_W-1:0]      r_hits;
    logic [sacf_pkg::CNT_W-1:0]      r_misses;
    logic [sacf_pkg::CNT_W-1:0]      r_reads;
    logic [sacf_pkg::CNT_W-1:0]      r_writes;

    sacf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    assign pready = 1'b1;

    sacf_addr_split #(
        .MAX_SETS   (MAX_SETS),
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_split (
        .i_addr (r_addr),
        .i_cfg  (w_cfg),
        .o_set  (w_set),
        .o_tag  (w_tag),
        .o_nw   (w_nw)
    );

    // tag reads: way 0 during decode, then one way ahead while scanning
    assign w_tag_re    = (r_state == S_DECODE) || (r_state == S_SCAN);
    assign w_tag_raddr = (r_state == S_DECODE) ? {w_set, WIDX_W'(0)}
                                               : {r_set, r_way + WIDX_W'(1)};
    assign w_tag_we    = (r_state == S_UPDATE) && w_found;

    sacf_tag_store #(
        .DEPTH_W (SIDX_W + WIDX_W),
        .DATA_W  (ADDR_WIDTH)
    ) u_tags (
        .i_clk     (i_clk),
        .i_rd_en   (w_tag_re),
        .i_rd_addr (w_tag_raddr),
        .i_wr_en   (w_tag_we),
        .i_wr_addr ({r_set, w_vic}),
        .i_wr_data (r_tag),
        .i_cmp_tag (r_tag),
        .o_match   (w_match)
    );

    assign w_addr_ext = {{ADDR_WIDTH{1'b0}}, i_address};

    // unpack the valid / rank row of the current set
    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            w_vld[i]  = r_meta_q[i*MW + sacf_pkg::RANK_W];
            w_rank[i] = r_meta_q[i*MW +: sacf_pkg::RANK_W];
        end
    end

    assign w_hit  = w_vld[r_way] && w_match;
    assign w_last = (WCMP_W'(r_way) == (WCMP_W'(r_nw) - WCMP_W'(1)));
    assign w_load = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    // victim: first way, in way order, that is invalid or at the oldest rank
    always_comb begin
        w_found = 1'b0;
        w_repl  = 1'b0;
        w_vic   = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (!w_found && (i < int'(r_nw))) begin
                if (w_rank[i] == r_nw) begin
                    w_found = 1'b1;
                    w_repl  = 1'b1;
                    w_vic   = WIDX_W'(i);
                end else if (!w_vld[i]) begin
                    w_found = 1'b1;
                    w_vic   = WIDX_W'(i);
                end
            end
        end
    end

    always_comb begin
        w_meta_new = r_meta_q;
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (w_found && (j < int'(r_nw))) begin
                if (j == int'(w_vic)) begin
                    w_meta_new[j*MW + sacf_pkg::RANK_W] = 1'b1;
                    w_meta_new[j*MW +: sacf_pkg::RANK_W] = sacf_pkg::RANK_W'(1);
                end else if (w_repl || (j < int'(w_vic))) begin
                    w_meta_new[j*MW +: sacf_pkg::RANK_W] = sacf_pkg::rank_bump(w_rank[j]);
                end
            end
        end
    end

    always_comb begin
        w_meta_we    = 1'b0;
        w_meta_waddr = r_set;
        w_meta_wdata = w_meta_new;
        if (r_state == S_CLEAR) begin
            w_meta_we    = 1'b1;
            w_meta_waddr = r_clr;
            w_meta_wdata = '0;
        end else if (r_state == S_UPDATE) begin
            w_meta_we = w_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_meta_we) begin
            r_meta_mem[w_meta_waddr] <= w_meta_wdata;
        end
        if (r_state == S_DECODE) begin
            r_meta_q <= r_meta_mem[w_set];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == '1) n_state = S_IDLE;
            S_IDLE:   if (i_in_valid) n_state = S_DECODE;
            S_DECODE: n_state = S_SCAN;
            S_SCAN: begin
                if (w_hit) begin
                    n_state = S_FINISH;
                end else if (w_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_FINISH;
            S_FINISH: if (w_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_reads     <= '0;
            r_writes    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + SIDX_W'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                if (r_hit) begin
                    r_hits <= sacf_pkg::sat_inc(r_hits);
                end else begin
                    r_misses <= sacf_pkg::sat_inc(r_misses);
                    r_reads  <= sacf_pkg::sat_inc(r_reads);
                end
                if (r_op == sacf_pkg::OP_WRITE) begin
                    r_writes <= sacf_pkg::sat_inc(r_writes);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_op   <= i_op;
            r_addr <= w_addr_ext[ADDR_WIDTH-1:0];
        end
        if (r_state == S_DECODE) begin
            r_set <= w_set;
            r_tag <= w_tag;
            r_nw  <= w_nw;
            r_way <= '0;
        end
        if (r_state == S_SCAN) begin
            r_hit <= w_hit;
            if (!w_hit && !w_last) begin
                r_way <= r_way + WIDX_W'(1);
            end
        end
        if (w_load) begin
            r_out_hit <= r_hit;
            r_out_op  <= r_op;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_mem_read    = !r_out_hit;
    assign o_mem_write   = r_out_op;
    // counters only move when a new result loads, so they track the held beat
    assign o_hit_count   = r_hits;
    assign o_miss_count  = r_misses;
    assign o_read_count  = r_reads;
    assign o_write_count = r_writes;

endmodule
